FILE: rtl/fdf_pkg.sv
`timescale 1ns / 1ps

package fdf_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_OWN_NODE_ID = 2'd0;
	localparam logic [1:0] REG_ENTRY_LIFETIME = 2'd1;
	localparam logic [1:0] REG_CAPACITY = 2'd2;

	localparam logic [31:0] OWN_NODE_ID_RESET = 32'd0;
	localparam logic [31:0] ENTRY_LIFETIME_RESET = 32'd30000;
	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic        header_valid;
		logic [31:0] src_node;
		logic [31:0] msg_num;
		logic [7:0]  frag_num;
		logic [7:0]  ttl_in;
		logic [7:0]  hops_in;
		logic [31:0] time_ms;
	} item_t;

	typedef struct packed {
		logic       is_duplicate;
		logic       deliver;
		logic       relay;
		logic [7:0] ttl_out;
		logic [7:0] hops_out;
	} result_t;

	typedef struct packed {
		logic [31:0] own_node_id;
		logic [31:0] entry_lifetime_ms;
		logic [4:0]  capacity_in_use;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic update;
	} cmd_t;

endpackage

FILE: rtl/flood_duplicate_filter_unit.sv
`timescale 1ns / 1ps

// Duplicate filter for a flooding mesh. A packet header is taken when start is
// high and busy is low. The next cycle compares the header against every
// cache entry in parallel (expiry and identity), the cycle after that updates
// the cache, and the result word appears on result with done high for exactly
// one cycle right after it. The receiver cannot stall: sample result whenever
// done is high. Busy is high only in the compare cycle, so with start held a
// new header is taken in each update step, while the cache is written for the
// header before it. The cache lives in flip-flops and is empty straight
// after reset; no clearing pass is needed. Configuration writes are always
// ready and must be issued only while no header is in flight.
module flood_duplicate_filter_unit #(
	parameter int CACHE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  fdf_pkg::item_t   item,
	output logic             done,
	output fdf_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	fdf_pkg::cfg_t cfg;
	fdf_pkg::cmd_t cmd;

	fdf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	fdf_datapath #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.item   (item),
		.result (result),
		.done   (done)
	);

endmodule

FILE: rtl/fdf_cfg_regs.sv
`timescale 1ns / 1ps

module fdf_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output fdf_pkg::cfg_t     cfg
);

	fdf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node_id <= fdf_pkg::OWN_NODE_ID_RESET;
			cfg_q.entry_lifetime_ms <= fdf_pkg::ENTRY_LIFETIME_RESET;
			cfg_q.capacity_in_use <= fdf_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fdf_pkg::REG_OWN_NODE_ID: begin
					cfg_q.own_node_id <= cfg_data;
				end
				fdf_pkg::REG_ENTRY_LIFETIME: begin
					cfg_q.entry_lifetime_ms <= cfg_data;
				end
				fdf_pkg::REG_CAPACITY: begin
					cfg_q.capacity_in_use <= cfg_data[4:0];
				end
				default: begin
					// Writes to unknown indexes are dropped.
				end
			endcase
		end
	end

endmodule

FILE: rtl/fdf_ctrl.sv
`timescale 1ns / 1ps

module fdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output fdf_pkg::cmd_t cmd
);

	fdf_pkg::state_t state_q;
	fdf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b0;
		cmd = '0;
		unique case (state_q)
			fdf_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = fdf_pkg::ST_CHECK;
				end
			end
			fdf_pkg::ST_CHECK: begin
				busy = 1'b1;
				cmd.check = 1'b1;
				state_d = fdf_pkg::ST_UPDATE;
			end
			fdf_pkg::ST_UPDATE: begin
				// The cache is written at the end of this cycle, so the next
				// word can already be captured here.
				cmd.update = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d = fdf_pkg::ST_CHECK;
				end else begin
					state_d = fdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/fdf_datapath.sv
`timescale 1ns / 1ps

module fdf_datapath #(
	parameter int CACHE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fdf_pkg::cmd_t    cmd,
	input  fdf_pkg::cfg_t    cfg,
	input  fdf_pkg::item_t   item,
	output fdf_pkg::result_t result,
	output logic             done
);

	localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

	// Slot 0 holds the newest entry; age grows with the index.
	logic [CACHE_DEPTH-1:0] slot_valid_q;
	logic [31:0]            slot_source_q [CACHE_DEPTH];
	logic [31:0]            slot_message_q [CACHE_DEPTH];
	logic [7:0]             slot_fragment_q [CACHE_DEPTH];
	logic [31:0]            slot_expiry_q [CACHE_DEPTH];

	fdf_pkg::item_t   item_q;
	fdf_pkg::result_t result_q;
	logic             done_q;

	logic [CACHE_DEPTH-1:0] survive_s1;
	logic                   match_s1;
	logic                   skip_s1;

	logic [CACHE_DEPTH-1:0] survive_d;
	logic [CACHE_DEPTH-1:0] hit_d;
	logic [31:0]            diff_d [CACHE_DEPTH];

	logic [CNT_W-1:0]       count_d;
	logic [CNT_W-1:0]       cap_eff_d;
	logic [CACHE_DEPTH-1:0] oldest_d;
	logic [CACHE_DEPTH-1:0] kept_d;
	logic [CACHE_DEPTH-1:0] shift_d;
	logic                   seen_d;
	logic                   evict_d;
	logic                   insert_d;
	logic                   relay_d;

	assign result = result_q;
	assign done = done_q;

	// Compare stage: expiry test and identity match on every slot at once.
	always_comb begin
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			diff_d[i] = item_q.time_ms - slot_expiry_q[i];
			// Still alive while now - expiry is negative as a signed value.
			survive_d[i] = slot_valid_q[i] & diff_d[i][31];
			hit_d[i] = survive_d[i] &&
				slot_source_q[i] == item_q.src_node &&
				slot_message_q[i] == item_q.msg_num &&
				slot_fragment_q[i] == item_q.frag_num;
		end
	end

	// Update stage: occupancy, eviction of the oldest survivor and insertion.
	always_comb begin
		count_d = '0;
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			count_d = count_d + CNT_W'(survive_s1[i]);
		end

		if (cfg.capacity_in_use == 5'd0) begin
			cap_eff_d = CNT_W'(1);
		end else if (32'(cfg.capacity_in_use) > 32'(CACHE_DEPTH)) begin
			cap_eff_d = CNT_W'(CACHE_DEPTH);
		end else begin
			cap_eff_d = CNT_W'(cfg.capacity_in_use);
		end

		seen_d = 1'b0;
		for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
			oldest_d[i] = survive_s1[i] & ~seen_d;
			seen_d = seen_d | survive_s1[i];
		end

		insert_d = ~skip_s1 & ~match_s1;
		evict_d = insert_d && (count_d >= cap_eff_d);
		kept_d = survive_s1 & ~(oldest_d & {CACHE_DEPTH{evict_d}});

		// A slot moves up by one when every newer slot is occupied, so the
		// shift stops at the first free slot and nothing valid is lost.
		shift_d[0] = 1'b1;
		for (int i = 1; i < CACHE_DEPTH; i++) begin
			shift_d[i] = shift_d[i-1] & kept_d[i-1];
		end

		relay_d = insert_d && (item_q.ttl_in != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update && !skip_s1) begin
				if (insert_d) begin
					for (int i = 0; i < CACHE_DEPTH; i++) begin
						slot_valid_q[i] <= shift_d[i] ? 1'b1 : kept_d[i];
					end
				end else begin
					slot_valid_q <= survive_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.check) begin
			survive_s1 <= survive_d;
			match_s1 <= |hit_d;
			skip_s1 <= ~item_q.header_valid ||
				item_q.src_node == cfg.own_node_id;
		end
		if (cmd.update) begin
			if (insert_d) begin
				slot_source_q[0] <= item_q.src_node;
				slot_message_q[0] <= item_q.msg_num;
				slot_fragment_q[0] <= item_q.frag_num;
				slot_expiry_q[0] <= item_q.time_ms + cfg.entry_lifetime_ms;
				for (int i = 1; i < CACHE_DEPTH; i++) begin
					if (shift_d[i]) begin
						slot_source_q[i] <= slot_source_q[i-1];
						slot_message_q[i] <= slot_message_q[i-1];
						slot_fragment_q[i] <= slot_fragment_q[i-1];
						slot_expiry_q[i] <= slot_expiry_q[i-1];
					end
				end
			end
			result_q.is_duplicate <= ~skip_s1 & match_s1;
			result_q.deliver <= insert_d;
			result_q.relay <= relay_d;
			result_q.ttl_out <= relay_d ? item_q.ttl_in - 8'd1 : 8'd0;
			result_q.hops_out <= relay_d ? item_q.hops_in + 8'd1 : 8'd0;
		end
	end

endmodule
